// ===== hw/rtl/sfep_pkg.sv =====
// Shared types and constants for the sparse feature elementwise product block.
// Used by sfep_ctrl, sfep_datapath and the top level; depends on nothing.
`default_nettype none

package sfep_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int INDEX_BITS = 32;
	localparam int VALUE_BITS = 32;
	localparam int PTR_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	localparam logic [INDEX_BITS-1:0] MASK_RESET = INDEX_BITS'(262143);
	localparam logic [VALUE_BITS-1:0] Q_ONE      = VALUE_BITS'(32'h0001_0000);

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_START  = 2'd2
	} sfep_op_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_ANCHOR   = 2'd1,
		ST_OUT_OF_ORDER = 2'd2,
		ST_OVERFLOW     = 2'd3
	} sfep_status_t;

	// controller to datapath
	typedef struct packed {
		logic         load_a;
		logic         load_b;
		logic         init_walk;
		logic         step;
		logic         mul;
		logic         emit_anchor;
		logic         emit_product;
		logic         emit_status;
		sfep_status_t code;
	} sfep_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic overflow;
		logic anchors_ok;
		logic more;
		logic order_bad;
		logic match;
		logic out_free;
	} sfep_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfep_ctrl.sv =====
// Sequencer for the sparse feature product: accepts words, runs the join walk.
// Depends on sfep_pkg for the command and status structs and the codes.
`default_nettype none

module sfep_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [1:0]         operation,
	output logic                    in_stall,
	input  wire sfep_pkg::sfep_stat_t st,
	output sfep_pkg::sfep_cmd_t     cmd
);
	import sfep_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ISSUE,
		S_COMPARE,
		S_MUL,
		S_EMIT,
		S_FINAL
	} state_t;

	state_t       state_q;
	sfep_status_t code_q;
	logic         accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_START) state_q <= S_START;
				end
				S_START: begin
					if (st.overflow) begin
						code_q  <= ST_OVERFLOW;
						state_q <= S_FINAL;
					end else if (!st.anchors_ok) begin
						code_q  <= ST_BAD_ANCHOR;
						state_q <= S_FINAL;
					end else if (st.out_free) begin
						code_q  <= ST_OK;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= st.more ? S_COMPARE : S_FINAL;
				end
				S_COMPARE: begin
					if (st.order_bad) begin
						code_q  <= ST_OUT_OF_ORDER;
						state_q <= S_FINAL;
					end else if (st.match) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_ISSUE;
					end
				end
				S_MUL: state_q <= S_EMIT;
				S_EMIT: begin
					if (st.out_free) state_q <= S_ISSUE;
				end
				S_FINAL: begin
					if (st.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd              = '0;
		cmd.code         = code_q;
		cmd.load_a       = accept && operation == OP_LOAD_A;
		cmd.load_b       = accept && operation == OP_LOAD_B;
		cmd.init_walk    = (state_q == S_START) && !st.overflow && st.anchors_ok && st.out_free;
		cmd.emit_anchor  = cmd.init_walk;
		cmd.step         = (state_q == S_COMPARE) && !st.order_bad;
		cmd.mul          = (state_q == S_MUL);
		cmd.emit_product = (state_q == S_EMIT) && st.out_free;
		cmd.emit_status  = (state_q == S_FINAL) && st.out_free;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfep_datapath.sv =====
// List stores, anchor registers, join offsets, Q16.16 multiplier and output word.
// Depends on sfep_pkg; driven by sfep_ctrl through the command struct.
`default_nettype none

module sfep_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               index_mask_we,
	input  wire logic [sfep_pkg::INDEX_BITS-1:0]    index_mask_wdata,
	input  wire logic [sfep_pkg::INDEX_BITS-1:0]    feature_index,
	input  wire logic signed [sfep_pkg::VALUE_BITS-1:0] feature_value,
	input  wire sfep_pkg::sfep_cmd_t                cmd,
	output sfep_pkg::sfep_stat_t                    st,
	input  wire logic                               out_stall,
	output logic                                    out_valid,
	output logic                                    has_product,
	output logic [sfep_pkg::INDEX_BITS-1:0]         product_index,
	output logic signed [sfep_pkg::VALUE_BITS-1:0]  product_value,
	output logic [1:0]                              status,
	output logic                                    last
);
	import sfep_pkg::*;

	logic [INDEX_BITS-1:0] mem_a_idx [LIST_DEPTH];
	logic [VALUE_BITS-1:0] mem_a_val [LIST_DEPTH];
	logic [INDEX_BITS-1:0] mem_b_idx [LIST_DEPTH];
	logic [VALUE_BITS-1:0] mem_b_val [LIST_DEPTH];

	logic [INDEX_BITS-1:0] mask_q;
	logic [CNT_W-1:0]      cnt_a_q, cnt_b_q, i_q, j_q;
	logic                  ovf_q;
	logic [INDEX_BITS-1:0] anc_a_idx_q, anc_b_idx_q, prev_a_q, prev_b_q;
	logic [VALUE_BITS-1:0] anc_a_val_q, anc_b_val_q;

	logic [INDEX_BITS-1:0] rd_a_idx_s1, rd_b_idx_s1;
	logic [VALUE_BITS-1:0] rd_a_val_s1, rd_b_val_s1;

	logic signed [VALUE_BITS-1:0]   mul_a_s1, mul_b_s1;
	logic [INDEX_BITS-1:0]          mul_idx_s1, prod_idx_s2;
	logic signed [2*VALUE_BITS-1:0] prod_s2;

	logic                          out_valid_q, out_has_q, out_last_q;
	logic [INDEX_BITS-1:0]         out_idx_q;
	logic signed [VALUE_BITS-1:0]  out_val_q;
	sfep_status_t                  out_status_q;

	logic                  full_a, full_b, wr_a, wr_b;
	logic [INDEX_BITS-1:0] off_a, off_b;
	logic                  prod_fits;
	logic [VALUE_BITS-1:0] prod_sat;

	assign full_a = (cnt_a_q == CNT_W'(LIST_DEPTH));
	assign full_b = (cnt_b_q == CNT_W'(LIST_DEPTH));
	assign wr_a   = cmd.load_a && !full_a;
	assign wr_b   = cmd.load_b && !full_b;

	// offsets from each anchor, wrapped by the mask
	assign off_a = ((rd_a_idx_s1 & mask_q) - (anc_a_idx_q & mask_q)) & mask_q;
	assign off_b = ((rd_b_idx_s1 & mask_q) - (anc_b_idx_q & mask_q)) & mask_q;

	// floor shift by 16, then clamp when the upper bits are not all sign
	assign prod_fits = (prod_s2[2*VALUE_BITS-1:VALUE_BITS+15] == '0)
	                || (prod_s2[2*VALUE_BITS-1:VALUE_BITS+15] == '1);
	always_comb begin
		if (prod_fits)
			prod_sat = prod_s2[VALUE_BITS+15:16];
		else if (prod_s2[2*VALUE_BITS-1])
			prod_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
		else
			prod_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
	end

	always_comb begin
		st            = '0;
		st.overflow   = ovf_q;
		st.anchors_ok = (cnt_a_q != '0) && (cnt_b_q != '0)
		             && (anc_a_val_q == Q_ONE) && (anc_b_val_q == Q_ONE);
		st.more       = (i_q < cnt_a_q) && (j_q < cnt_b_q);
		st.order_bad  = (off_a < prev_a_q) || (off_b < prev_b_q);
		st.match      = (off_a == off_b);
		st.out_free   = !out_valid_q || !out_stall;
	end

	// list stores; read ports follow the walk pointers every cycle
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a_idx[cnt_a_q[PTR_W-1:0]] <= feature_index;
			mem_a_val[cnt_a_q[PTR_W-1:0]] <= feature_value;
		end
		if (wr_b) begin
			mem_b_idx[cnt_b_q[PTR_W-1:0]] <= feature_index;
			mem_b_val[cnt_b_q[PTR_W-1:0]] <= feature_value;
		end
		rd_a_idx_s1 <= mem_a_idx[i_q[PTR_W-1:0]];
		rd_a_val_s1 <= mem_a_val[i_q[PTR_W-1:0]];
		rd_b_idx_s1 <= mem_b_idx[j_q[PTR_W-1:0]];
		rd_b_val_s1 <= mem_b_val[j_q[PTR_W-1:0]];
	end

	// anchors and multiplier stages carry no reset
	always_ff @(posedge clk) begin
		if (wr_a && cnt_a_q == '0) begin
			anc_a_idx_q <= feature_index;
			anc_a_val_q <= feature_value;
		end
		if (wr_b && cnt_b_q == '0) begin
			anc_b_idx_q <= feature_index;
			anc_b_val_q <= feature_value;
		end
		if (cmd.step && st.match) begin
			mul_a_s1   <= rd_a_val_s1;
			mul_b_s1   <= rd_b_val_s1;
			mul_idx_s1 <= rd_a_idx_s1;
		end
		if (cmd.mul) begin
			prod_s2     <= mul_a_s1 * mul_b_s1;
			prod_idx_s2 <= mul_idx_s1;
		end
		if (cmd.emit_anchor) begin
			out_has_q    <= 1'b1;
			out_idx_q    <= anc_a_idx_q;
			out_val_q    <= Q_ONE;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else if (cmd.emit_product) begin
			out_has_q    <= 1'b1;
			out_idx_q    <= prod_idx_s2;
			out_val_q    <= prod_sat;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else if (cmd.emit_status) begin
			out_has_q    <= 1'b0;
			out_idx_q    <= '0;
			out_val_q    <= '0;
			out_status_q <= cmd.code;
			out_last_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= MASK_RESET;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			prev_a_q    <= '0;
			prev_b_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (index_mask_we) mask_q <= index_mask_wdata;
			if (cmd.emit_status) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (wr_a) cnt_a_q <= cnt_a_q + CNT_W'(1);
				if (wr_b) cnt_b_q <= cnt_b_q + CNT_W'(1);
				if ((cmd.load_a && full_a) || (cmd.load_b && full_b)) ovf_q <= 1'b1;
			end
			if (cmd.init_walk) begin
				i_q      <= CNT_W'(1);
				j_q      <= CNT_W'(1);
				prev_a_q <= '0;
				prev_b_q <= '0;
			end else if (cmd.step) begin
				if (st.match || off_a < off_b) i_q <= i_q + CNT_W'(1);
				if (st.match || off_a > off_b) j_q <= j_q + CNT_W'(1);
				prev_a_q <= off_a;
				prev_b_q <= off_b;
			end
			if (cmd.emit_anchor || cmd.emit_product || cmd.emit_status)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign has_product   = out_has_q;
	assign product_index = out_idx_q;
	assign product_value = out_val_q;
	assign status        = out_status_q;
	assign last          = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_feature_elementwise_product.sv =====
// Top level of the sparse feature elementwise product (merge join of two lists).
// Depends on sfep_pkg, sfep_ctrl and sfep_datapath.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    operation, feature_index, feature_value
//   out       output     out_valid / out_stall  has_product, product_index,
//                                               product_value, status, last
//   config    input      index_mask_we          index_mask_wdata
//
// A load word is taken at once while idle; the next word may follow at once.
// A start word runs: the anchor check, then for each join step a list store read
// and then an offset compare, for each match a multiply and then output, then the
// check that finds the walk done and the final status word. The read and multiply
// steps come from the registered read port on each store and the registered multiplier.
// Reset clears the counts and overflow flag, loads the default mask and idles the
// sequencer; the list stores are not cleared.
// in_stall is high for the whole run; out_stall holds the output word and
// pauses the run until the word is taken.
`default_nettype none

module sparse_feature_elementwise_product (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   index_mask_we,
	input  wire logic [sfep_pkg::INDEX_BITS-1:0]        index_mask_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [1:0]                             operation,
	input  wire logic [sfep_pkg::INDEX_BITS-1:0]        feature_index,
	input  wire logic signed [sfep_pkg::VALUE_BITS-1:0] feature_value,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        has_product,
	output logic [sfep_pkg::INDEX_BITS-1:0]             product_index,
	output logic signed [sfep_pkg::VALUE_BITS-1:0]      product_value,
	output logic [1:0]                                  status,
	output logic                                        last
);
	import sfep_pkg::*;

	sfep_cmd_t  cmd;
	sfep_stat_t st;

	// sequencer: accepts words, steps the join
	sfep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// stores, offsets, multiplier and output word
	sfep_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.index_mask_we    (index_mask_we),
		.index_mask_wdata (index_mask_wdata),
		.feature_index    (feature_index),
		.feature_value    (feature_value),
		.cmd              (cmd),
		.st               (st),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.has_product      (has_product),
		.product_index    (product_index),
		.product_value    (product_value),
		.status           (status),
		.last             (last)
	);

	// a start word always puts the input side on hold for the run
	a_start_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_START |=> in_stall)
		else $error("start word did not hold the input side");

	// product words never close a run and always report ok
	a_product_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_product |-> !last && status == ST_OK)
		else $error("product word flagged as last or with bad status");

	// the status word closes the run and carries no product
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_product |-> last && product_index == '0 && product_value == '0)
		else $error("status word malformed");

	// a stalled output word holds still until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(has_product)
			&& $stable(product_index) && $stable(product_value)
			&& $stable(status) && $stable(last))
		else $error("stalled output word changed");

endmodule

`default_nettype wire
